/* hw/rtl/slf_pkg.sv */
// ---------------------------------------------------------------------------
// slf_pkg
// Types, constants and helpers shared by the line-follow control core.
// ---------------------------------------------------------------------------
`default_nettype none
package slf_pkg;

    localparam int CW = 40;   // CORDIC datapath width
    localparam int ZW = 34;   // CORDIC angle accumulator width

    localparam logic [27:0] INVK_Q28 = 28'd163008219;
    localparam logic [29:0] INVK_Q30 = 30'd652032874;
    localparam logic [31:0] ONE_Q31  = 32'h8000_0000;
    localparam logic [31:0] ANG_HALF = 32'h8000_0000;

    localparam logic [2:0] REG_START_X = 3'd0;
    localparam logic [2:0] REG_START_Y = 3'd1;
    localparam logic [2:0] REG_END_X   = 3'd2;
    localparam logic [2:0] REG_END_Y   = 3'd3;
    localparam logic [2:0] REG_RADIUS  = 3'd4;
    localparam logic [2:0] REG_CLOSE   = 3'd5;
    localparam logic [2:0] REG_EXP     = 3'd6;
    localparam logic [2:0] REG_SAILMAX = 3'd7;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_SQRT,
        OP_DIV
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    typedef struct packed {
        logic start;
        logic vec;   // 1: vectoring, 0: rotation
    } cordic_cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LINE,
        ST_LINE_W,
        ST_EMUL,
        ST_EMUL_W,
        ST_TACK,
        ST_ATN_W,
        ST_HEAD,
        ST_COS_W,
        ST_CSQ,
        ST_CSQ_W,
        ST_PI_R,
        ST_PI_RW,
        ST_PI_B,
        ST_PI_BW,
        ST_PF_SQ,
        ST_PF_SQW,
        ST_PF_R,
        ST_PF_RW,
        ST_DIV,
        ST_DIV_W,
        ST_DONE
    } seq_state_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        begin
            unique case (idx)
                5'd0:    v = 32'h20000000;
                5'd1:    v = 32'h12E4051E;
                5'd2:    v = 32'h09FB385B;
                5'd3:    v = 32'h051111D4;
                5'd4:    v = 32'h028B0D43;
                5'd5:    v = 32'h0145D7E1;
                5'd6:    v = 32'h00A2F61E;
                5'd7:    v = 32'h00517C55;
                5'd8:    v = 32'h0028BE53;
                5'd9:    v = 32'h00145F2F;
                5'd10:   v = 32'h000A2F98;
                5'd11:   v = 32'h000517CC;
                5'd12:   v = 32'h00028BE6;
                5'd13:   v = 32'h000145F3;
                5'd14:   v = 32'h0000A2FA;
                5'd15:   v = 32'h0000517D;
                5'd16:   v = 32'h000028BE;
                5'd17:   v = 32'h0000145F;
                5'd18:   v = 32'h00000A30;
                5'd19:   v = 32'h00000518;
                5'd20:   v = 32'h0000028C;
                5'd21:   v = 32'h00000146;
                5'd22:   v = 32'h000000A3;
                5'd23:   v = 32'h00000051;
                default: v = 32'h0;
            endcase
            return v;
        end
    endfunction

    function automatic logic signed [CW-1:0] sx40(input logic [31:0] v);
        begin
            return {{(CW-32){v[31]}}, v};
        end
    endfunction

    // |a| > 32768 - z, a taken as a signed 16-bit angle
    function automatic logic upwind(input logic [15:0] a, input logic [13:0] z);
        logic signed [16:0] a17;
        logic [16:0]        m;
        logic [16:0]        lim;
        begin
            a17 = {a[15], a};
            m   = a[15] ? 17'(-a17) : 17'(a17);
            lim = 17'd32768 - {3'b000, z};
            return m > lim;
        end
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/slf_cordic.sv */
// ---------------------------------------------------------------------------
// slf_cordic
// Iterative CORDIC, one micro-rotation per cycle, vectoring or rotation.
// ---------------------------------------------------------------------------
`default_nettype none
module slf_cordic #(
    parameter int STEPS = 16
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  slf_pkg::cordic_cmd_t                 cmd,
    input  wire logic signed [slf_pkg::CW-1:0]   x0,
    input  wire logic signed [slf_pkg::CW-1:0]   y0,
    input  wire logic signed [slf_pkg::CW-1:0]   u0,
    input  wire logic signed [slf_pkg::CW-1:0]   v0,
    input  wire logic signed [slf_pkg::ZW-1:0]   z0,
    output logic                                 busy,
    output logic                                 done,
    output logic signed [slf_pkg::CW-1:0]        x,
    output logic signed [slf_pkg::CW-1:0]        y,
    output logic signed [slf_pkg::CW-1:0]        u,
    output logic signed [slf_pkg::CW-1:0]        v,
    output logic signed [slf_pkg::ZW-1:0]        z
);
    import slf_pkg::*;

    logic                 busy_reg, busy_next, done_reg, done_next, vec_reg, vec_next;
    logic [4:0]           cnt_reg, cnt_next;
    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next, u_reg, u_next, v_reg, v_next;
    logic signed [ZW-1:0] z_reg, z_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vec_reg <= vec_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        u_reg   <= u_next;
        v_reg   <= v_next;
        z_reg   <= z_next;
    end

    always_comb
    begin
        logic signed [CW-1:0] xs, ys, us, vs;
        logic signed [ZW-1:0] at;
        logic                 s;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        vec_next  = vec_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        u_next    = u_reg;
        v_next    = v_reg;
        z_next    = z_reg;
        xs = x_reg >>> cnt_reg;
        ys = y_reg >>> cnt_reg;
        us = u_reg >>> cnt_reg;
        vs = v_reg >>> cnt_reg;
        at = signed'({{(ZW-32){1'b0}}, atan_lut(cnt_reg)});
        s  = vec_reg ? !y_reg[CW-1] : z_reg[ZW-1];
        if (cmd.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            vec_next  = cmd.vec;
            x_next    = x0;
            y_next    = y0;
            u_next    = u0;
            v_next    = v0;
            z_next    = z0;
        end
        else if (busy_reg)
        begin
            if (s)
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                u_next = u_reg + vs;
                v_next = v_reg - us;
                z_next = z_reg + at;
            end
            else
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                u_next = u_reg - vs;
                v_next = v_reg + us;
                z_next = z_reg - at;
            end
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign x    = x_reg;
    assign y    = y_reg;
    assign u    = u_reg;
    assign v    = v_reg;
    assign z    = z_reg;

endmodule
`default_nettype wire

/* hw/rtl/slf_arith.sv */
// ---------------------------------------------------------------------------
// slf_arith
// Bit-serial multiply, square root and divide unit.
// ---------------------------------------------------------------------------
`default_nettype none
module slf_arith (
    input  wire                      clk,
    input  wire                      rst_n,
    input  slf_pkg::arith_req_t      req,
    input  wire logic [63:0]         a,
    input  wire logic [31:0]         b,
    output logic                     busy,
    output logic                     done,
    output logic [63:0]              res
);
    import slf_pkg::*;

    logic        busy_reg, busy_next, done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    arith_op_t   op_reg, op_next;
    logic [63:0] acc_reg, acc_next, sh_reg, sh_next, bit_reg, bit_next;
    logic [31:0] b_reg, b_next;
    logic [32:0] rem_reg, rem_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_MUL;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            op_reg   <= op_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        sh_reg  <= sh_next;
        bit_reg <= bit_next;
        b_reg   <= b_next;
        rem_reg <= rem_next;
    end

    always_comb
    begin
        logic [63:0] t;
        logic [32:0] rt;
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        acc_next  = acc_reg;
        sh_next   = sh_reg;
        bit_next  = bit_reg;
        b_next    = b_reg;
        rem_next  = rem_reg;
        t  = acc_reg + bit_reg;
        rt = {rem_reg[31:0], sh_reg[31]};
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            op_next   = req.op;
            acc_next  = '0;
            sh_next   = a;
            b_next    = b;
            bit_next  = 64'h4000_0000_0000_0000;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                OP_MUL:
                begin
                    if (b_reg[0])
                    begin
                        acc_next = acc_reg + sh_reg;
                    end
                    sh_next = {sh_reg[62:0], 1'b0};
                    b_next  = {1'b0, b_reg[31:1]};
                end
                OP_SQRT:
                begin
                    if (sh_reg >= t)
                    begin
                        sh_next  = sh_reg - t;
                        acc_next = {1'b0, acc_reg[63:1]} + bit_reg;
                    end
                    else
                    begin
                        acc_next = {1'b0, acc_reg[63:1]};
                    end
                    bit_next = {2'b00, bit_reg[63:2]};
                end
                OP_DIV:
                begin
                    if (rt >= {1'b0, b_reg})
                    begin
                        rem_next = rt - {1'b0, b_reg};
                        acc_next = {acc_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = rt;
                        acc_next = {acc_reg[62:0], 1'b0};
                    end
                    sh_next = {sh_reg[62:0], 1'b0};
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign res  = acc_reg;

endmodule
`default_nettype wire

/* hw/rtl/sailboat_line_follow_control_core.sv */
// Throughput: one request at a time; s_axis_tready is high only while idle.
// Reset: asynchronous active-low; control and config registers reset, tack side positive.
// ---------------------------------------------------------------------------
// sailboat_line_follow_control_core
// Line-following sailboat controller: cross-track error, desired heading,
// upwind override, rudder and sail setpoints.
// ---------------------------------------------------------------------------
`default_nettype none
module sailboat_line_follow_control_core #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [31:0]  cfg_data,
    input  wire               s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [95:0]  s_axis_tdata,   // pos_x, pos_y, heading, wind_dir
    output logic              m_axis_tvalid,
    input  wire               m_axis_tready,
    output logic [39:0]       m_axis_tdata    // rudder_setpoint, sail_setpoint, close_hauled
);
    import slf_pkg::*;

    logic signed [31:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic [23:0] rad_reg;
    logic [13:0] chz_reg;
    logic [15:0] exp_reg;
    logic [14:0] smax_reg;

    seq_state_t state_reg, state_next;
    logic       tack_reg, tack_next;
    logic       mval_reg, mval_next;
    logic [39:0] mdata_reg, mdata_next;

    logic signed [CW-1:0] px_reg, px_next, py_reg, py_next, e_reg, e_next;
    logic [31:0] phi_reg, phi_next;
    logic [15:0] head_reg, head_next, wind_reg, wind_next, tb_reg, tb_next;
    logic [15:0] rud_reg, rud_next, sail_reg, sail_next;
    logic        ch_flag_reg, ch_flag_next;
    logic [30:0] cos_reg, cos_next;
    logic [31:0] pr_reg, pr_next, pb_reg, pb_next, ps_reg, ps_next;
    logic [3:0]  j_reg, j_next;

    cordic_cmd_t          ccmd;
    logic signed [CW-1:0] cx0, cy0, cu0, cv0, cx, cy, cu, cv;
    logic signed [ZW-1:0] cz0, cz;
    logic                 cbusy, cdone;

    arith_req_t  areq;
    logic [63:0] aa, ares;
    logic [31:0] ab;
    logic        abusy, adone;

    slf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk(clk), .rst_n(rst_n), .cmd(ccmd),
        .x0(cx0), .y0(cy0), .u0(cu0), .v0(cv0), .z0(cz0),
        .busy(cbusy), .done(cdone),
        .x(cx), .y(cy), .u(cu), .v(cv), .z(cz)
    );

    slf_arith u_arith (
        .clk(clk), .rst_n(rst_n), .req(areq), .a(aa), .b(ab),
        .busy(abusy), .done(adone), .res(ares)
    );

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg   <= '0;
            sy_reg   <= '0;
            ex_reg   <= 32'sd256;
            ey_reg   <= '0;
            rad_reg  <= 24'd1536;
            chz_reg  <= 14'd8192;
            exp_reg  <= 16'd4096;
            smax_reg <= 15'd16384;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_START_X: sx_reg   <= cfg_data;
                REG_START_Y: sy_reg   <= cfg_data;
                REG_END_X:   ex_reg   <= cfg_data;
                REG_END_Y:   ey_reg   <= cfg_data;
                REG_RADIUS:  rad_reg  <= cfg_data[23:0];
                REG_CLOSE:   chz_reg  <= cfg_data[13:0];
                REG_EXP:     exp_reg  <= cfg_data[15:0];
                REG_SAILMAX: smax_reg <= cfg_data[14:0];
                default:     sx_reg   <= sx_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tack_reg  <= 1'b0;
            mval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tack_reg  <= tack_next;
            mval_reg  <= mval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mdata_reg   <= mdata_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        e_reg       <= e_next;
        phi_reg     <= phi_next;
        head_reg    <= head_next;
        wind_reg    <= wind_next;
        tb_reg      <= tb_next;
        rud_reg     <= rud_next;
        sail_reg    <= sail_next;
        ch_flag_reg <= ch_flag_next;
        cos_reg     <= cos_next;
        pr_reg      <= pr_next;
        pb_reg      <= pb_next;
        ps_reg      <= ps_next;
        j_reg       <= j_next;
    end

    always_comb
    begin
        logic signed [CW-1:0] dx, dy, ae, rr;
        logic [CW-1:0]        mag;
        logic [35:0]          q36;
        logic [31:0]          tb32, phr, tbr;
        logic [15:0]          tb16, d16;
        logic [23:0]          reff;
        logic [14:0]          seff;
        logic [34:0]          cw35;
        logic [31:0]          qd;
        logic                 ovr;
        state_next   = state_reg;
        tack_next    = tack_reg;
        mval_next    = mval_reg;
        mdata_next   = mdata_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        e_next       = e_reg;
        phi_next     = phi_reg;
        head_next    = head_reg;
        wind_next    = wind_reg;
        tb_next      = tb_reg;
        rud_next     = rud_reg;
        sail_next    = sail_reg;
        ch_flag_next = ch_flag_reg;
        cos_next     = cos_reg;
        pr_next      = pr_reg;
        pb_next      = pb_reg;
        ps_next      = ps_reg;
        j_next       = j_reg;
        ccmd         = '{start: 1'b0, vec: 1'b1};
        cx0 = '0;
        cy0 = '0;
        cu0 = '0;
        cv0 = '0;
        cz0 = '0;
        areq = '{start: 1'b0, op: OP_MUL};
        aa   = '0;
        ab   = '0;
        s_axis_tready = 1'b0;

        reff = (rad_reg == 24'd0) ? 24'd1 : rad_reg;
        seff = (smax_reg == 15'd0) ? 15'd1 : smax_reg;
        rr   = signed'({{(CW-24){1'b0}}, reff});
        dx   = sx40(ex_reg) - sx40(sx_reg);
        dy   = sx40(ey_reg) - sx40(sy_reg);
        mag  = py_reg[CW-1] ? unsigned'(-py_reg) : unsigned'(py_reg);
        ae   = e_reg[CW-1] ? -e_reg : e_reg;
        q36  = 36'((ares + 64'h0FFF_FFFF) >> 28);
        tb32 = phi_reg - cz[31:0];
        phr  = phi_reg + 32'h8000;
        tbr  = tb32 + 32'h8000;
        tb16 = tbr[31:16];
        ovr  = upwind(wind_reg - tb16, chz_reg) ||
               ((ae < rr) && upwind(wind_reg - phr[31:16], chz_reg));
        d16  = wind_reg - tb_reg;
        cw35 = ares[63:29];
        qd   = ares[31:0];

        if (mval_reg && m_axis_tready)
        begin
            mval_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    px_next   = sx40(s_axis_tdata[31:0]) - sx40(sx_reg);
                    py_next   = sx40(s_axis_tdata[63:32]) - sx40(sy_reg);
                    head_next = s_axis_tdata[79:64];
                    wind_next = s_axis_tdata[95:80];
                    state_next = ST_LINE;
                end
            end
            ST_LINE:
            begin
                if (dx == '0 && dy == '0)
                begin
                    e_next     = py_reg;
                    phi_next   = '0;
                    state_next = ST_TACK;
                end
                else
                begin
                    ccmd.start = 1'b1;
                    if (dx[CW-1])
                    begin
                        cx0      = -dx;
                        cy0      = -dy;
                        cu0      = -px_reg;
                        cv0      = -py_reg;
                        phi_next = ANG_HALF;
                    end
                    else
                    begin
                        cx0      = dx;
                        cy0      = dy;
                        cu0      = px_reg;
                        cv0      = py_reg;
                        phi_next = '0;
                    end
                    state_next = ST_LINE_W;
                end
            end
            ST_LINE_W:
            begin
                if (cdone)
                begin
                    phi_next   = phi_reg + cz[31:0];
                    py_next    = cv;
                    state_next = ST_EMUL;
                end
            end
            ST_EMUL:
            begin
                areq       = '{start: 1'b1, op: OP_MUL};
                aa         = 64'(mag);
                ab         = 32'(INVK_Q28);
                state_next = ST_EMUL_W;
            end
            ST_EMUL_W:
            begin
                if (adone)
                begin
                    e_next = py_reg[CW-1] ? -signed'(CW'(q36)) : signed'(CW'(ares[63:28]));
                    state_next = ST_TACK;
                end
            end
            ST_TACK:
            begin
                if (ae > rr)
                begin
                    tack_next = e_reg[CW-1];
                end
                ccmd       = '{start: 1'b1, vec: 1'b1};
                cx0        = rr;
                cy0        = e_reg;
                state_next = ST_ATN_W;
            end
            ST_ATN_W:
            begin
                if (cdone)
                begin
                    if (ovr)
                    begin
                        tb_next = tack_reg ? 16'h8000 + wind_reg + {2'b00, chz_reg}
                                           : 16'h8000 + wind_reg - {2'b00, chz_reg};
                    end
                    else
                    begin
                        tb_next = tb16;
                    end
                    ch_flag_next = ovr;
                    state_next   = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                rud_next   = head_reg - tb_reg + 16'h8000;
                ccmd       = '{start: 1'b1, vec: 1'b0};
                cx0        = signed'(CW'(INVK_Q30));
                cz0        = signed'({{(ZW-31){d16[15]}}, d16, 15'b0});
                state_next = ST_COS_W;
            end
            ST_COS_W:
            begin
                if (cdone)
                begin
                    if (cx[CW-1])
                    begin
                        cos_next = '0;
                    end
                    else if (cx > signed'(CW'(64'h4000_0000)))
                    begin
                        cos_next = 31'h4000_0000;
                    end
                    else
                    begin
                        cos_next = cx[30:0];
                    end
                    state_next = ST_CSQ;
                end
            end
            ST_CSQ:
            begin
                areq       = '{start: 1'b1, op: OP_MUL};
                aa         = 64'(cos_reg);
                ab         = 32'(cos_reg);
                state_next = ST_CSQ_W;
            end
            ST_CSQ_W:
            begin
                if (adone)
                begin
                    pb_next    = (cw35 > 35'(ONE_Q31)) ? ONE_Q31 : cw35[31:0];
                    ps_next    = (cw35 > 35'(ONE_Q31)) ? ONE_Q31 : cw35[31:0];
                    pr_next    = ONE_Q31;
                    j_next     = '0;
                    state_next = ST_PI_R;
                end
            end
            ST_PI_R:
            begin
                if (exp_reg[4'd12 + j_reg])
                begin
                    areq       = '{start: 1'b1, op: OP_MUL};
                    aa         = 64'(pr_reg);
                    ab         = pb_reg;
                    state_next = ST_PI_RW;
                end
                else
                begin
                    state_next = ST_PI_B;
                end
            end
            ST_PI_RW:
            begin
                if (adone)
                begin
                    pr_next    = ares[62:31];
                    state_next = ST_PI_B;
                end
            end
            ST_PI_B:
            begin
                areq       = '{start: 1'b1, op: OP_MUL};
                aa         = 64'(pb_reg);
                ab         = pb_reg;
                state_next = ST_PI_BW;
            end
            ST_PI_BW:
            begin
                if (adone)
                begin
                    pb_next = ares[62:31];
                    if (j_reg == 4'd3)
                    begin
                        j_next     = 4'd1;
                        state_next = ST_PF_SQ;
                    end
                    else
                    begin
                        j_next     = j_reg + 4'd1;
                        state_next = ST_PI_R;
                    end
                end
            end
            ST_PF_SQ:
            begin
                areq       = '{start: 1'b1, op: OP_SQRT};
                aa         = {1'b0, ps_reg, 31'b0};
                state_next = ST_PF_SQW;
            end
            ST_PF_SQW:
            begin
                if (adone)
                begin
                    ps_next    = ares[31:0];
                    state_next = ST_PF_R;
                end
            end
            ST_PF_R:
            begin
                if (exp_reg[4'd12 - j_reg])
                begin
                    areq       = '{start: 1'b1, op: OP_MUL};
                    aa         = 64'(pr_reg);
                    ab         = ps_reg;
                    state_next = ST_PF_RW;
                end
                else if (j_reg == 4'd12)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    j_next     = j_reg + 4'd1;
                    state_next = ST_PF_SQ;
                end
            end
            ST_PF_RW:
            begin
                if (adone)
                begin
                    pr_next = ares[62:31];
                    if (j_reg == 4'd12)
                    begin
                        state_next = ST_DIV;
                    end
                    else
                    begin
                        j_next     = j_reg + 4'd1;
                        state_next = ST_PF_SQ;
                    end
                end
            end
            ST_DIV:
            begin
                areq       = '{start: 1'b1, op: OP_DIV};
                aa         = 64'(pr_reg);
                ab         = {16'b0, seff, 1'b0};
                state_next = ST_DIV_W;
            end
            ST_DIV_W:
            begin
                if (adone)
                begin
                    sail_next  = (qd > 32'd65535) ? 16'hFFFF : qd[15:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!mval_reg || m_axis_tready)
                begin
                    mdata_next = {7'b0, ch_flag_reg, sail_reg, rud_reg};
                    mval_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = mval_reg;
    assign m_axis_tdata  = mdata_reg;

    a_cordic_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ccmd.start |-> !cbusy)
        else $error("cordic started while busy");

    a_arith_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        areq.start |-> !abusy)
        else $error("arith unit started while busy");

    a_idle_units_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!cbusy && !abusy))
        else $error("unit busy while sequencer idle");

    a_done_loads_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && !mval_reg) |=> (mval_reg && state_reg == ST_IDLE))
        else $error("result not loaded");

endmodule
`default_nettype wire
